FILE: sv/dehw_pkg.sv
// Package: phase codes, level kinds, event and error codes, tag constants and VR helpers.
`timescale 1ns / 1ps

package dehw_pkg;

    localparam logic [3:0] PH_PREAMBLE    = 4'd0;
    localparam logic [3:0] PH_MAGIC       = 4'd1;
    localparam logic [3:0] PH_META        = 4'd2;
    localparam logic [3:0] PH_SKIP        = 4'd3;
    localparam logic [3:0] PH_HEADER      = 4'd4;
    localparam logic [3:0] PH_OFFSET      = 4'd5;
    localparam logic [3:0] PH_OFFSET_SKIP = 4'd6;
    localparam logic [3:0] PH_STREAM      = 4'd7;
    localparam logic [3:0] PH_DONE        = 4'd8;
    localparam logic [3:0] PH_ERROR       = 4'd9;

    localparam logic [1:0] K_TOP  = 2'd0;
    localparam logic [1:0] K_SEQ  = 2'd1;
    localparam logic [1:0] K_ITEM = 2'd2;
    localparam logic [1:0] K_FRAG = 2'd3;

    localparam logic [2:0] EV_ELEMENT    = 3'd0;
    localparam logic [2:0] EV_ITEM_START = 3'd1;
    localparam logic [2:0] EV_ITEM_END   = 3'd2;
    localparam logic [2:0] EV_SEQ_END    = 3'd3;
    localparam logic [2:0] EV_STREAM     = 3'd4;
    localparam logic [2:0] EV_ERROR      = 3'd5;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_MAGIC     = 4'd1;
    localparam logic [3:0] ERR_META      = 4'd2;
    localparam logic [3:0] ERR_VR        = 4'd3;
    localparam logic [3:0] ERR_PADDING   = 4'd4;
    localparam logic [3:0] ERR_ORDER     = 4'd5;
    localparam logic [3:0] ERR_DELIMITER = 4'd6;
    localparam logic [3:0] ERR_TAG       = 4'd7;
    localparam logic [3:0] ERR_UNDEFINED = 4'd8;
    localparam logic [3:0] ERR_DEPTH     = 4'd9;

    localparam logic [31:0] T_ITEM     = 32'hFFFE_E000;
    localparam logic [31:0] T_ITEM_END = 32'hFFFE_E00D;
    localparam logic [31:0] T_SEQ_END  = 32'hFFFE_E0DD;
    localparam logic [31:0] T_PIXEL    = 32'h7FE0_0010;
    localparam logic [31:0] T_META     = 32'h0002_0000;
    localparam logic [31:0] UNDEF_LEN  = 32'hFFFF_FFFF;

    localparam logic [15:0] VR_UL = 16'h554C;
    localparam logic [15:0] VR_SQ = 16'h5351;
    localparam logic [15:0] VR_OB = 16'h4F42;
    localparam logic [15:0] VR_OW = 16'h4F57;

    // Result transaction
    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] group;
        logic [15:0] element;
        logic [15:0] vr_code;
        logic [31:0] value_length;
        logic [4:0]  nest_depth;
        logic [3:0]  error_code;
    } result_t;

    // VRs with a 16-bit length field
    function automatic logic vr_is16(input logic [15:0] vr);
        logic r;
        r = 1'b0;
        unique case (vr)
            16'h4145, 16'h4153, 16'h4154, 16'h4353, 16'h4441, 16'h4453, 16'h4454,
            16'h4644, 16'h464C, 16'h4953, 16'h4C4F, 16'h4C54, 16'h504E, 16'h5348,
            16'h534C, 16'h5353, 16'h5354, 16'h544D, 16'h5549, 16'h554C,
            16'h5553: r = 1'b1;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic [7:0] magic_byte(input logic [1:0] i);
        logic [7:0] r;
        unique case (i)
            2'd0: r = 8'h44;
            2'd1: r = 8'h49;
            2'd2: r = 8'h43;
            default: r = 8'h4D;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/dehw_in_stage.sv
// Input register stage: captures one byte per transaction, holds while stalled.
`timescale 1ns / 1ps

module dehw_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       q_valid,
    output logic [7:0] q_byte,
    input  logic       q_take
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // Accept when empty or when the held byte leaves this cycle
    assign in_stall = valid_reg && !q_take;
    assign q_valid  = valid_reg;
    assign q_byte   = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

FILE: sv/dehw_core.sv
// Parser core: header walker state, level stack and per-byte result logic.
`timescale 1ns / 1ps

module dehw_core
    import dehw_pkg::*;
#(
    parameter int MAX_DEPTH      = 16,
    parameter int PREAMBLE_BYTES = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] b,
    output logic       res_valid,
    output result_t    res
);

    localparam int SPW = $clog2(MAX_DEPTH + 1);
    localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [3:0]     phase_reg, phase_next;
    logic [7:0]     idx_reg, idx_next;
    logic [31:0]    tag_reg, tag_next;
    logic [15:0]    vr_reg, vr_next;
    logic [31:0]    len_reg, len_next;
    logic [31:0]    skip_reg, skip_next;
    logic [31:0]    top_last_reg, top_last_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [1:0]     kind_reg [MAX_DEPTH];
    logic [31:0]    last_reg [MAX_DEPTH];

    logic           push_en, set_last;
    logic [1:0]     push_kind;
    logic [31:0]    last_val;

    logic [AW-1:0]  top_idx;
    logic [1:0]     ctx;
    logic [31:0]    lvl_last;

    assign top_idx  = AW'(sp_reg - SPW'(1));
    assign ctx      = (sp_reg == '0) ? K_TOP : kind_reg[top_idx];
    assign lvl_last = last_reg[top_idx];

    always_comb
    begin
        logic        expl, short_hdr, ex_gather, full;
        logic [31:0] t, ln;
        logic [15:0] v;
        logic [4:0]  d;
        logic        fail;
        logic [3:0]  code;
        logic        emit;
        logic [2:0]  ev;

        phase_next    = phase_reg;
        idx_next      = idx_reg;
        tag_next      = tag_reg;
        vr_next       = vr_reg;
        len_next      = len_reg;
        skip_next     = skip_reg;
        top_last_next = top_last_reg;
        sp_next       = sp_reg;
        push_en       = 1'b0;
        push_kind     = K_TOP;
        set_last      = 1'b0;
        last_val      = '0;
        fail          = 1'b0;
        code          = ERR_NONE;
        emit          = 1'b0;
        ev            = EV_ELEMENT;
        expl          = 1'b0;
        short_hdr     = 1'b0;
        ex_gather     = 1'b0;
        full          = (sp_reg >= SPW'(MAX_DEPTH));
        d             = 5'(sp_reg);

        // Gather the header byte
        if (phase_reg == PH_HEADER)
        begin
            expl      = (ctx == K_TOP) || (ctx == K_ITEM);
            short_hdr = !expl || (ctx == K_ITEM && idx_reg >= 8'd4 && tag_reg == T_ITEM_END);
            ex_gather = !short_hdr;
        end
        else if (phase_reg == PH_META)
        begin
            ex_gather = 1'b1;
        end
        if ((phase_reg == PH_HEADER || phase_reg == PH_OFFSET || phase_reg == PH_STREAM ||
             (phase_reg == PH_META && idx_reg < 8'd8)))
        begin
            if (idx_reg < 8'd4)
            begin
                if (idx_reg == 8'd0)
                begin
                    tag_next = '0;
                    vr_next  = '0;
                end
                unique case (idx_reg[1:0])
                    2'd0: tag_next[23:16] = b;
                    2'd1: tag_next[31:24] = b;
                    2'd2: tag_next[7:0]   = b;
                    default: tag_next[15:8] = b;
                endcase
            end
            else if (!ex_gather)
            begin
                if (idx_reg < 8'd8)
                begin
                    if (idx_reg == 8'd4) len_next = '0;
                    len_next[idx_reg[1:0]*8 +: 8] = b;
                end
            end
            else if (idx_reg < 8'd6)
            begin
                if (idx_reg == 8'd4) vr_next = {b, 8'h00};
                else vr_next[7:0] = b;
            end
            else if (idx_reg < 8'd8)
            begin
                if (idx_reg == 8'd6) len_next = '0;
                len_next[(idx_reg[0] ? 8 : 0) +: 8] = b;
            end
            else if (idx_reg < 8'd12)
            begin
                if (idx_reg == 8'd8) len_next = '0;
                len_next[idx_reg[1:0]*8 +: 8] = b;
            end
        end
        t  = tag_next;
        v  = vr_next;
        ln = len_next;

        unique case (phase_reg)
            PH_PREAMBLE:
            begin
                idx_next = idx_reg + 8'd1;
                if (idx_next >= 8'(PREAMBLE_BYTES))
                begin
                    idx_next   = '0;
                    phase_next = PH_MAGIC;
                end
            end
            PH_MAGIC:
            begin
                if (b != magic_byte(idx_reg[1:0]))
                begin
                    fail = 1'b1;
                    code = ERR_MAGIC;
                end
                else
                begin
                    idx_next = idx_reg + 8'd1;
                    if (idx_next >= 8'd4)
                    begin
                        idx_next   = '0;
                        phase_next = PH_META;
                    end
                end
            end
            PH_META:
            begin
                idx_next = idx_reg + 8'd1;
                if (idx_reg == 8'd3 && t != T_META)
                begin
                    fail = 1'b1;
                    code = ERR_META;
                end
                else if (idx_reg == 8'd5 && v != VR_UL)
                begin
                    fail = 1'b1;
                    code = ERR_META;
                end
                else if (idx_reg == 8'd7)
                begin
                    if (ln != 32'd4)
                    begin
                        fail = 1'b1;
                        code = ERR_META;
                    end
                    else
                    begin
                        emit = 1'b1;
                        ev   = EV_ELEMENT;
                        d    = '0;
                    end
                end
                else if (idx_reg >= 8'd8)
                begin
                    if (idx_reg == 8'd8) skip_next = '0;
                    skip_next[idx_reg[1:0]*8 +: 8] = b;
                    if (idx_reg >= 8'd11)
                    begin
                        idx_next   = '0;
                        phase_next = (skip_next == '0) ? PH_HEADER : PH_SKIP;
                    end
                end
            end
            PH_SKIP, PH_OFFSET_SKIP:
            begin
                if (skip_reg != '0) skip_next = skip_reg - 32'd1;
                if (skip_next == '0)
                    phase_next = (phase_reg == PH_SKIP) ? PH_HEADER : PH_STREAM;
            end
            PH_HEADER:
            begin
                logic fin;
                fin = 1'b0;
                idx_next = idx_reg + 8'd1;
                if (idx_reg == 8'd3)
                begin
                    // Tag checks
                    if (ctx == K_TOP)
                    begin
                        if (t <= top_last_reg)
                        begin
                            fail = 1'b1;
                            code = ERR_ORDER;
                        end
                        else if (t > T_PIXEL)
                        begin
                            fail = 1'b1;
                            code = ERR_TAG;
                        end
                    end
                    else if (ctx == K_ITEM)
                    begin
                        if (t <= lvl_last)
                        begin
                            fail = 1'b1;
                            code = ERR_ORDER;
                        end
                        else if (t != T_ITEM_END && t[31:16] == 16'hFFFE)
                        begin
                            fail = 1'b1;
                            code = ERR_TAG;
                        end
                    end
                    else if (t != T_ITEM && t != T_SEQ_END)
                    begin
                        fail = 1'b1;
                        code = ERR_TAG;
                    end
                end
                else if (short_hdr)
                begin
                    if (idx_reg >= 8'd7) fin = 1'b1;
                end
                else if (idx_reg == 8'd5 && (!is_letter(v[15:8]) || !is_letter(v[7:0])))
                begin
                    fail = 1'b1;
                    code = ERR_VR;
                end
                else if (idx_reg == 8'd7 && vr_is16(v))
                begin
                    fin = 1'b1;
                end
                else if (idx_reg == 8'd7 && ln != '0)
                begin
                    fail = 1'b1;
                    code = ERR_PADDING;
                end
                else if (idx_reg >= 8'd11)
                begin
                    fin = 1'b1;
                end

                // Finish the header
                if (fin)
                begin
                    idx_next = '0;
                    if (ctx == K_TOP || ctx == K_ITEM)
                    begin
                        if (ctx == K_ITEM && t == T_ITEM_END)
                        begin
                            if (ln != '0)
                            begin
                                fail = 1'b1;
                                code = ERR_DELIMITER;
                            end
                            else
                            begin
                                sp_next = sp_reg - SPW'(1);
                                emit    = 1'b1;
                                ev      = EV_ITEM_END;
                                v       = '0;
                            end
                        end
                        else
                        begin
                            if (ctx == K_TOP) top_last_next = t;
                            else
                            begin
                                set_last = 1'b1;
                                last_val = t;
                            end
                            if (ctx == K_TOP && t == T_PIXEL)
                            begin
                                if (v != VR_OB && v != VR_OW)
                                begin
                                    fail = 1'b1;
                                    code = ERR_VR;
                                end
                                else if (ln != UNDEF_LEN)
                                begin
                                    fail = 1'b1;
                                    code = ERR_UNDEFINED;
                                end
                                else if (full)
                                begin
                                    fail = 1'b1;
                                    code = ERR_DEPTH;
                                end
                                else
                                begin
                                    push_en    = 1'b1;
                                    push_kind  = K_FRAG;
                                    phase_next = PH_OFFSET;
                                end
                            end
                            else if (ln == UNDEF_LEN)
                            begin
                                if (t == T_PIXEL)
                                begin
                                    if (v != VR_OB && v != VR_OW)
                                    begin
                                        fail = 1'b1;
                                        code = ERR_VR;
                                    end
                                    else if (full)
                                    begin
                                        fail = 1'b1;
                                        code = ERR_DEPTH;
                                    end
                                    else
                                    begin
                                        push_en   = 1'b1;
                                        push_kind = K_FRAG;
                                    end
                                end
                                else if (v != VR_SQ)
                                begin
                                    fail = 1'b1;
                                    code = ERR_UNDEFINED;
                                end
                                else if (full)
                                begin
                                    fail = 1'b1;
                                    code = ERR_DEPTH;
                                end
                                else
                                begin
                                    push_en   = 1'b1;
                                    push_kind = K_SEQ;
                                end
                            end
                            else if (ln != '0)
                            begin
                                skip_next  = ln;
                                phase_next = PH_SKIP;
                            end
                            if (!fail)
                            begin
                                emit = 1'b1;
                                ev   = EV_ELEMENT;
                            end
                        end
                    end
                    else if (t == T_SEQ_END)
                    begin
                        if (ln != '0)
                        begin
                            fail = 1'b1;
                            code = ERR_DELIMITER;
                        end
                        else
                        begin
                            sp_next = sp_reg - SPW'(1);
                            emit    = 1'b1;
                            ev      = EV_SEQ_END;
                            v       = '0;
                        end
                    end
                    else
                    begin
                        if (ln == UNDEF_LEN)
                        begin
                            if (ctx == K_FRAG)
                            begin
                                fail = 1'b1;
                                code = ERR_UNDEFINED;
                            end
                            else if (full)
                            begin
                                fail = 1'b1;
                                code = ERR_DEPTH;
                            end
                            else
                            begin
                                push_en   = 1'b1;
                                push_kind = K_ITEM;
                            end
                        end
                        else if (ln != '0)
                        begin
                            skip_next  = ln;
                            phase_next = PH_SKIP;
                        end
                        if (!fail)
                        begin
                            emit = 1'b1;
                            ev   = EV_ITEM_START;
                            v    = '0;
                        end
                    end
                end
            end
            PH_OFFSET, PH_STREAM:
            begin
                idx_next = idx_reg + 8'd1;
                if (idx_reg == 8'd3 && t != T_ITEM)
                begin
                    fail = 1'b1;
                    code = ERR_TAG;
                end
                else if (idx_reg >= 8'd7)
                begin
                    idx_next = '0;
                    v        = '0;
                    if (phase_reg == PH_STREAM)
                    begin
                        phase_next = PH_DONE;
                        emit       = 1'b1;
                        ev         = EV_STREAM;
                    end
                    else if (ln == UNDEF_LEN)
                    begin
                        fail = 1'b1;
                        code = ERR_UNDEFINED;
                    end
                    else
                    begin
                        if (ln == '0) phase_next = PH_STREAM;
                        else
                        begin
                            skip_next  = ln;
                            phase_next = PH_OFFSET_SKIP;
                        end
                        emit = 1'b1;
                        ev   = EV_ITEM_START;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Error overrides the phase, stack and result updates
        if (fail)
        begin
            phase_next = PH_ERROR;
            sp_next    = sp_reg;
            push_en    = 1'b0;
            set_last   = 1'b0;
            res_valid  = 1'b1;
            res        = '{EV_ERROR, 16'h0, 16'h0, 16'h0, 32'h0, 5'(sp_reg), code};
        end
        else
        begin
            if (push_en) sp_next = sp_reg + SPW'(1);
            res_valid = emit;
            res       = '{ev, t[31:16], t[15:0], v, ln, d, ERR_NONE};
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= (PREAMBLE_BYTES > 0) ? PH_PREAMBLE : PH_MAGIC;
            idx_reg      <= '0;
            tag_reg      <= '0;
            vr_reg       <= '0;
            len_reg      <= '0;
            skip_reg     <= '0;
            top_last_reg <= '0;
            sp_reg       <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            tag_reg      <= tag_next;
            vr_reg       <= vr_next;
            len_reg      <= len_next;
            skip_reg     <= skip_next;
            top_last_reg <= top_last_next;
            sp_reg       <= sp_next;
        end
    end

    // Level stack: push writes the new top, a header tag updates the current top;
    // both can happen on the same byte
    always_ff @(posedge clk)
    begin
        if (step && push_en)
        begin
            kind_reg[AW'(sp_reg)] <= push_kind;
            last_reg[AW'(sp_reg)] <= '0;
        end
        if (step && set_last)
        begin
            last_reg[top_idx] <= last_val;
        end
    end

endmodule

FILE: sv/dehw_out_stage.sv
// Output register: holds one result transaction until the receiver takes it.
`timescale 1ns / 1ps

module dehw_out_stage
    import dehw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    load_valid,
    input  result_t load_res,
    output logic    free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load && load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load && load_valid)
        begin
            res_reg <= load_res;
        end
    end

endmodule

FILE: sv/dicom_element_header_walker_top.sv
// Top level of the DICOM explicit-VR little-endian element header walker.
`timescale 1ns / 1ps
//
// Input channel: in_valid / in_stall with data_byte, one file byte per transaction.
// Output channel: out_valid / out_stall with one header event per transaction
// (event_res, group, element, vr_code, value_length, nest_depth, error_code).
// A byte is registered at the input, processed combinationally by the walker core,
// and its result (if any) lands in the output register when the core steps, which it
// does only while the output register is empty or being emptied.
// Throughput is one byte per cycle while the receiver does not stall.
// Most bytes produce no result; only the last byte of a header, or an error, does.
// When the receiver stalls with a result waiting, the core holds the pending byte
// and in_stall rises once the input register is full; no transaction is lost.
// After an error the walker emits one error event and ignores later bytes;
// after the stream fragment header it ignores all further bytes.
// Reset (rst_n low, asynchronous) clears both valid flags and returns the walker
// to the preamble phase (if any) with an empty level stack; no clearing pass.
//
module dicom_element_header_walker_top
    import dehw_pkg::*;
#(
    parameter int MAX_DEPTH      = 16,
    parameter int PREAMBLE_BYTES = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [15:0] group,
    output logic [15:0] element,
    output logic [15:0] vr_code,
    output logic [31:0] value_length,
    output logic [4:0]  nest_depth,
    output logic [3:0]  error_code
);

    logic       q_valid, step, free, res_valid;
    logic [7:0] q_byte;
    result_t    res, out_res;

    assign step = q_valid && free;

    dehw_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (data_byte),
        .q_valid  (q_valid),
        .q_byte   (q_byte),
        .q_take   (step)
    );

    dehw_core #(
        .MAX_DEPTH      (MAX_DEPTH),
        .PREAMBLE_BYTES (PREAMBLE_BYTES)
    ) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .b         (q_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    dehw_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .load_valid (res_valid),
        .load_res   (res),
        .free       (free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (out_res)
    );

    assign event_res    = out_res.event_res;
    assign group        = out_res.group;
    assign element      = out_res.element;
    assign vr_code      = out_res.vr_code;
    assign value_length = out_res.value_length;
    assign nest_depth   = out_res.nest_depth;
    assign error_code   = out_res.error_code;

`ifndef ASSERT_OFF
    // An error event always carries a nonzero code
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_ERROR |-> error_code != ERR_NONE)
        else $error("error event without code");

    // Non-error events carry no code
    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_ERROR |-> error_code == ERR_NONE)
        else $error("code on non-error event");

    // Core only steps when the output side can take its result
    a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> free)
        else $error("step without room");

    // Nesting depth never exceeds the stack size
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> nest_depth <= 5'(MAX_DEPTH))
        else $error("depth out of range");
`endif

endmodule
